/* rtl/acr_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, axis codes and pipeline word types for the box collision resolver.
package acr_pkg;

	localparam int CoordW = 32;              // Q16.16 center coordinate
	localparam int DistW  = CoordW + 1;      // center difference
	localparam int ExtW   = 31;              // extent sum
	localparam int Ov2W   = DistW + 2;       // doubled overlap, 2|d| - ext
	localparam int MassW  = 16;              // Q8.8 mass
	localparam int WsumW  = MassW + 1;       // mass_a + mass_b
	localparam int PenW   = ExtW;            // doubled penetration on a hit
	localparam int ProdW  = PenW + MassW;    // penetration times mass
	localparam int QuoW   = PenW - 1;        // push magnitude, below pen2 / 2
	localparam int DenW   = WsumW + 1;       // divisor 2 * (mass_a + mass_b)
	localparam int RemW   = DenW;            // partial remainder
	localparam int NumCells = QuoW;          // one quotient bit per cell

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// Per-pair data that rides alongside the divider
	typedef struct packed {
		logic             hit;
		logic [1:0]       axis;
		logic             neg_a;   // A moves toward minus
		logic             pos_b;   // B moves toward minus
		logic             stat_a;
		logic             stat_b;
		logic             wzero;   // both masses zero
		logic [PenW-1:0]  pen2;
		logic [WsumW-1:0] wsum;
	} side_t;

	// Word passed from cell to cell
	typedef struct packed {
		logic [RemW-1:0] rem;
		logic [QuoW-1:0] num_lo;   // dividend bits not yet shifted in
		logic [DenW-1:0] den;
		logic [QuoW-1:0] quo;
		side_t           side;
	} div_t;

endpackage

/* rtl/acr_front.sv */
`timescale 1ns / 1ps
// Front pipeline: center distances, overlaps, hit and axis pick, dividend product.
module acr_front import acr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [CoordW-1:0] center_a_x,
	input  logic signed [CoordW-1:0] center_a_y,
	input  logic signed [CoordW-1:0] center_a_z,
	input  logic signed [CoordW-1:0] center_b_x,
	input  logic signed [CoordW-1:0] center_b_y,
	input  logic signed [CoordW-1:0] center_b_z,
	input  logic [ExtW-1:0]          extent_sum_x,
	input  logic [ExtW-1:0]          extent_sum_y,
	input  logic [ExtW-1:0]          extent_sum_z,
	input  logic [MassW-1:0]         mass_a,
	input  logic [MassW-1:0]         mass_b,
	input  logic [1:0]               static_flags,
	output logic                     out_valid,
	output div_t                     out_word,
	input  logic                     out_stall
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic stall_s1, stall_s2, stall_s3, stall_s4;

	logic signed [DistW-1:0] dist_s1 [3];
	logic [ExtW-1:0]         ext_s1 [3];
	logic [MassW-1:0]        ma_s1, mb_s1, ma_s2, mb_s2, mb_s3;
	logic [1:0]              stat_s1, stat_s2;

	logic signed [Ov2W-1:0]  ov2_c [3];
	logic signed [Ov2W-1:0]  ov2_s2 [3];
	logic [2:0]              neg_s2, pos_s2;

	side_t                   side_c, side_s3;
	logic signed [Ov2W-1:0]  sel_ov;
	logic signed [Ov2W-1:0]  pen_full;
	logic                    gt01, gt02, gt12;

	logic [ProdW-1:0]        prod;
	div_t                    word_c, word_s4;

	// Each stage holds while it is full and the next one holds
	assign stall_s4 = valid_s4 & out_stall;
	assign stall_s3 = valid_s3 & stall_s4;
	assign stall_s2 = valid_s2 & stall_s3;
	assign stall_s1 = valid_s1 & stall_s2;
	assign in_stall = stall_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (!stall_s1) valid_s1 <= in_valid;
			if (!stall_s2) valid_s2 <= valid_s1;
			if (!stall_s3) valid_s3 <= valid_s2;
			if (!stall_s4) valid_s4 <= valid_s3;
		end
	end

	// Stage 1: center differences
	always_ff @(posedge clk) begin
		if (!stall_s1 && in_valid) begin
			dist_s1[0] <= {center_a_x[CoordW-1], center_a_x} - {center_b_x[CoordW-1], center_b_x};
			dist_s1[1] <= {center_a_y[CoordW-1], center_a_y} - {center_b_y[CoordW-1], center_b_y};
			dist_s1[2] <= {center_a_z[CoordW-1], center_a_z} - {center_b_z[CoordW-1], center_b_z};
			ext_s1[0]  <= extent_sum_x;
			ext_s1[1]  <= extent_sum_y;
			ext_s1[2]  <= extent_sum_z;
			ma_s1      <= mass_a;
			mb_s1      <= mass_b;
			stat_s1    <= static_flags;
		end
	end

	// Stage 2: doubled overlap 2|d| - ext, both signs formed in parallel
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dist_s1[i][DistW-1])
				ov2_c[i] = -{dist_s1[i][DistW-1], dist_s1[i], 1'b0}
					- $signed({4'b0, ext_s1[i]});
			else
				ov2_c[i] = {dist_s1[i][DistW-1], dist_s1[i], 1'b0}
					- $signed({4'b0, ext_s1[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s2 && valid_s1) begin
			for (int i = 0; i < 3; i++) begin
				ov2_s2[i] <= ov2_c[i];
				neg_s2[i] <= dist_s1[i][DistW-1];
				pos_s2[i] <= !dist_s1[i][DistW-1] && (dist_s1[i] != '0);
			end
			ma_s2   <= ma_s1;
			mb_s2   <= mb_s1;
			stat_s2 <= stat_s1;
		end
	end

	// Stage 3: hit test, least-penetration axis, penetration magnitude
	assign gt01 = ov2_s2[0] > ov2_s2[1];
	assign gt02 = ov2_s2[0] > ov2_s2[2];
	assign gt12 = ov2_s2[1] > ov2_s2[2];

	always_comb begin
		side_c.hit    = ov2_s2[0][Ov2W-1] & ov2_s2[1][Ov2W-1] & ov2_s2[2][Ov2W-1];
		side_c.axis   = gt01 ? (gt02 ? AXIS_X : AXIS_Z) : (gt12 ? AXIS_Y : AXIS_Z);
		side_c.stat_a = stat_s2[0];
		side_c.stat_b = stat_s2[1];
		side_c.wsum   = {1'b0, ma_s2} + {1'b0, mb_s2};
		side_c.wzero  = (ma_s2 == '0) && (mb_s2 == '0);
		case (side_c.axis)
			AXIS_X: begin
				sel_ov       = ov2_s2[0];
				side_c.neg_a = neg_s2[0];
				side_c.pos_b = pos_s2[0];
			end
			AXIS_Y: begin
				sel_ov       = ov2_s2[1];
				side_c.neg_a = neg_s2[1];
				side_c.pos_b = pos_s2[1];
			end
			default: begin
				sel_ov       = ov2_s2[2];
				side_c.neg_a = neg_s2[2];
				side_c.pos_b = pos_s2[2];
			end
		endcase
		pen_full    = -sel_ov;
		side_c.pen2 = pen_full[PenW-1:0];
	end

	always_ff @(posedge clk) begin
		if (!stall_s3 && valid_s2) begin
			side_s3 <= side_c;
			mb_s3   <= mb_s2;
		end
	end

	// Stage 4: dividend pen2 * mass_b; divisor 2 * (mass_a + mass_b)
	assign prod = ProdW'(side_s3.pen2) * ProdW'(mb_s3);

	always_comb begin
		word_c.rem    = RemW'(prod[ProdW-1:QuoW]);
		word_c.num_lo = prod[QuoW-1:0];
		word_c.den    = {side_s3.wsum, 1'b0};
		word_c.quo    = '0;
		word_c.side   = side_s3;
	end

	always_ff @(posedge clk) begin
		if (!stall_s4 && valid_s3) word_s4 <= word_c;
	end

	assign out_valid = valid_s4;
	assign out_word  = word_s4;

endmodule

/* rtl/acr_div_cell.sv */
`timescale 1ns / 1ps
// One restoring-division cell: settles one quotient bit and passes the word on.
module acr_div_cell import acr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  div_t in_word,
	output logic in_stall,
	output logic out_valid,
	output div_t out_word,
	input  logic out_stall
);

	logic            valid_q;
	div_t            word_q;
	div_t            next_word;
	logic [RemW:0]   trial;
	logic [RemW:0]   diff;
	logic            take;

	assign in_stall = valid_q & out_stall;

	// Shift in the next dividend bit, subtract the divisor when it fits
	always_comb begin
		trial     = {in_word.rem, in_word.num_lo[QuoW-1]};
		diff      = trial - {1'b0, in_word.den};
		take      = trial >= {1'b0, in_word.den};
		next_word = in_word;
		next_word.rem    = take ? diff[RemW-1:0] : trial[RemW-1:0];
		next_word.num_lo = {in_word.num_lo[QuoW-2:0], 1'b0};
		next_word.quo    = {in_word.quo[QuoW-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) word_q <= next_word;
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

/* rtl/acr_back.sv */
`timescale 1ns / 1ps
// Back end: push magnitudes for both boxes, sign and axis placement, output register.
module acr_back import acr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  div_t                     in_word,
	output logic                     in_stall,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     hit,
	output logic signed [CoordW-1:0] move_a_x,
	output logic signed [CoordW-1:0] move_a_y,
	output logic signed [CoordW-1:0] move_a_z,
	output logic signed [CoordW-1:0] move_b_x,
	output logic signed [CoordW-1:0] move_b_y,
	output logic signed [CoordW-1:0] move_b_z
);

	logic            valid_s1, valid_q;
	logic            stall_s1, stall_q;

	logic [QuoW-1:0] half, quarter, qb;
	logic [RemW-1:0] thr;
	logic            borrow;
	logic [QuoW-1:0] mag_a_c, mag_b_c;

	logic [QuoW-1:0] mag_a_s1, mag_b_s1;
	logic            hit_s1, neg_a_s1, pos_b_s1;
	logic [1:0]      axis_s1;

	logic [CoordW-1:0] sa, sb;

	assign stall_q  = valid_q & out_stall;
	assign stall_s1 = valid_s1 & stall_q;
	assign in_stall = stall_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (!stall_s1) valid_s1 <= in_valid;
			if (!stall_q) valid_q <= valid_s1;
		end
	end

	// B's share comes from A's quotient and remainder:
	// qb = pen2/2 - qa - (rem > (pen2 odd ? wsum : 0))
	always_comb begin
		half    = in_word.side.pen2[PenW-1:1];
		quarter = {1'b0, in_word.side.pen2[PenW-1:2]};
		thr     = in_word.side.pen2[0] ? {1'b0, in_word.side.wsum} : '0;
		borrow  = in_word.rem > thr;
		qb      = half - in_word.quo - QuoW'(borrow);

		if (!in_word.side.hit || in_word.side.stat_a)
			mag_a_c = '0;
		else if (in_word.side.stat_b)
			mag_a_c = half;
		else if (in_word.side.wzero)
			mag_a_c = quarter;
		else
			mag_a_c = in_word.quo;

		if (!in_word.side.hit || in_word.side.stat_b)
			mag_b_c = '0;
		else if (in_word.side.stat_a)
			mag_b_c = half;
		else if (in_word.side.wzero)
			mag_b_c = quarter;
		else
			mag_b_c = qb;
	end

	always_ff @(posedge clk) begin
		if (!stall_s1 && in_valid) begin
			mag_a_s1 <= mag_a_c;
			mag_b_s1 <= mag_b_c;
			hit_s1   <= in_word.side.hit;
			neg_a_s1 <= in_word.side.neg_a;
			pos_b_s1 <= in_word.side.pos_b;
			axis_s1  <= in_word.side.axis;
		end
	end

	// Apply direction and place on the chosen axis
	assign sa = neg_a_s1 ? (CoordW'(0) - CoordW'(mag_a_s1)) : CoordW'(mag_a_s1);
	assign sb = pos_b_s1 ? (CoordW'(0) - CoordW'(mag_b_s1)) : CoordW'(mag_b_s1);

	always_ff @(posedge clk) begin
		if (!stall_q && valid_s1) begin
			hit      <= hit_s1;
			move_a_x <= (axis_s1 == AXIS_X) ? sa : '0;
			move_a_y <= (axis_s1 == AXIS_Y) ? sa : '0;
			move_a_z <= (axis_s1 == AXIS_Z) ? sa : '0;
			move_b_x <= (axis_s1 == AXIS_X) ? sb : '0;
			move_b_y <= (axis_s1 == AXIS_Y) ? sb : '0;
			move_b_z <= (axis_s1 == AXIS_Z) ? sb : '0;
		end
	end

	assign out_valid = valid_q;

endmodule

/* rtl/aabb_collide_resolve_top.sv */
`timescale 1ns / 1ps
// Top level of the axis-aligned box collision resolver.
// One box pair enters per clock while no stall holds it, passing four front stages
// (distances, overlaps, axis pick, mass product), a row of 30 division cells that each
// settle one bit of the mass-weighted push, and two back stages that derive the second
// box's share, apply direction and register the result. Every stage moves on
// independently, so empty slots close up while the output word waits, and in_stall rises
// only once every stage holds a word.
module aabb_collide_resolve_top import acr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [CoordW-1:0] center_a_x,
	input  logic signed [CoordW-1:0] center_a_y,
	input  logic signed [CoordW-1:0] center_a_z,
	input  logic signed [CoordW-1:0] center_b_x,
	input  logic signed [CoordW-1:0] center_b_y,
	input  logic signed [CoordW-1:0] center_b_z,
	input  logic [ExtW-1:0]          extent_sum_x,
	input  logic [ExtW-1:0]          extent_sum_y,
	input  logic [ExtW-1:0]          extent_sum_z,
	input  logic [MassW-1:0]         mass_a,
	input  logic [MassW-1:0]         mass_b,
	input  logic [1:0]               static_flags,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     hit,
	output logic signed [CoordW-1:0] move_a_x,
	output logic signed [CoordW-1:0] move_a_y,
	output logic signed [CoordW-1:0] move_a_z,
	output logic signed [CoordW-1:0] move_b_x,
	output logic signed [CoordW-1:0] move_b_y,
	output logic signed [CoordW-1:0] move_b_z
);

	logic cell_valid [NumCells+1];
	logic cell_stall [NumCells+1];
	div_t cell_word  [NumCells+1];

	// Geometry front end
	acr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.center_a_x   (center_a_x),
		.center_a_y   (center_a_y),
		.center_a_z   (center_a_z),
		.center_b_x   (center_b_x),
		.center_b_y   (center_b_y),
		.center_b_z   (center_b_z),
		.extent_sum_x (extent_sum_x),
		.extent_sum_y (extent_sum_y),
		.extent_sum_z (extent_sum_z),
		.mass_a       (mass_a),
		.mass_b       (mass_b),
		.static_flags (static_flags),
		.out_valid    (cell_valid[0]),
		.out_word     (cell_word[0]),
		.out_stall    (cell_stall[0])
	);

	// Division row, one quotient bit per cell
	for (genvar g = 0; g < NumCells; g++) begin : g_cell
		acr_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cell_valid[g]),
			.in_word   (cell_word[g]),
			.in_stall  (cell_stall[g]),
			.out_valid (cell_valid[g+1]),
			.out_word  (cell_word[g+1]),
			.out_stall (cell_stall[g+1])
		);
	end

	// Push shares and output register
	acr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cell_valid[NumCells]),
		.in_word   (cell_word[NumCells]),
		.in_stall  (cell_stall[NumCells]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.move_a_x  (move_a_x),
		.move_a_y  (move_a_y),
		.move_a_z  (move_a_z),
		.move_b_x  (move_b_x),
		.move_b_y  (move_b_y),
		.move_b_z  (move_b_z)
	);

	// A miss never moves anything
	a_miss_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> move_a_x == '0 && move_a_y == '0 && move_a_z == '0 &&
			move_b_x == '0 && move_b_y == '0 && move_b_z == '0)
		else $error("move on a word without hit");

	// Both boxes move along one axis at most
	a_one_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({(move_a_x != '0) || (move_b_x != '0),
			(move_a_y != '0) || (move_b_y != '0),
			(move_a_z != '0) || (move_b_z != '0)}) <= 1)
		else $error("moves on more than one axis");

	// Input holds only when the whole pipe is full behind a held output
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input held while the pipe has room");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for the box collision resolver: directed and random pairs, scoreboard.
module testbench;
	import acr_pkg::*;

	localparam longint ONE      = 65536;          // 1.0 in Q16.16
	localparam longint CMAX     = 2147483647;
	localparam longint CMIN     = -CMAX - 1;
	localparam longint EXT_MAX  = 2147483647;
	localparam logic [1:0] STAT_A = 2'b01;
	localparam logic [1:0] STAT_B = 2'b10;
	localparam int N_RAND       = 1725;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 80;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int CYCLE_LIMIT  = 1500000;
	localparam int PRINT_CAP    = 40;

	// One box pair, index by axis code
	typedef struct packed {
		logic [2:0][CoordW-1:0] ca;
		logic [2:0][CoordW-1:0] cb;
		logic [2:0][ExtW-1:0]   ext;
		logic [MassW-1:0]       mass_a;
		logic [MassW-1:0]       mass_b;
		logic [1:0]             flags;
	} pair_t;

	// One resolved result
	typedef struct packed {
		logic                   hit;
		logic [2:0][CoordW-1:0] move_a;
		logic [2:0][CoordW-1:0] move_b;
	} res_t;

	// Expected separation words and their comparison
	class collide_board;
		res_t want_q[$];
		int   errors;
		int   checked;
		int   hits;

		// separation predicted for one pair
		function res_t resolve(pair_t p);
			longint     d[3];
			longint     ov2[3];
			longint     ad, pen2, w, num, den, mag;
			logic [1:0] axis;
			logic       sa, sb, on;
			res_t       r;
			int         i;
			r  = '0;
			on = 1'b1;
			sa = (p.flags & STAT_A) != 0;
			sb = (p.flags & STAT_B) != 0;
			for (i = 0; i < 3; i++) begin
				d[i]   = longint'($signed(p.ca[i])) - longint'($signed(p.cb[i]));
				ad     = d[i] < 0 ? -d[i] : d[i];
				ov2[i] = 2 * ad - longint'(p.ext[i]);
				if (ov2[i] >= 0)
					on = 1'b0;
			end
			if (!on)
				return r;
			r.hit = 1'b1;
			// least penetration; ties fall toward the later axis
			if (ov2[AXIS_X] > ov2[AXIS_Y])
				axis = (ov2[AXIS_X] > ov2[AXIS_Z]) ? AXIS_X : AXIS_Z;
			else
				axis = (ov2[AXIS_Y] > ov2[AXIS_Z]) ? AXIS_Y : AXIS_Z;
			pen2 = -ov2[axis];
			w    = longint'(p.mass_a) + longint'(p.mass_b);
			if (!sa) begin
				if (sb) begin
					num = 1; den = 1;
				end else if (w == 0) begin
					num = 1; den = 2;
				end else begin
					num = longint'(p.mass_b); den = w;
				end
				mag = (pen2 * num) / (2 * den);
				r.move_a[axis] = (d[axis] < 0) ? CoordW'(-mag) : CoordW'(mag);
			end
			if (!sb) begin
				if (sa) begin
					num = 1; den = 1;
				end else if (w == 0) begin
					num = 1; den = 2;
				end else begin
					num = longint'(p.mass_a); den = w;
				end
				mag = (pen2 * num) / (2 * den);
				r.move_b[axis] = (d[axis] > 0) ? CoordW'(-mag) : CoordW'(mag);
			end
			return r;
		endfunction

		function void note_pair(pair_t p);
			want_q.insert(want_q.size(), resolve(p));
		endfunction

		function int pending();
			return want_q.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_CAP)
				$display("mismatch at %0t: %s", $time, msg);
		endtask

		// compare one output word against the oldest expectation
		task check_move(res_t got);
			res_t want;
			int   i;
			if (want_q.size() == 0) begin
				report("result word with no pair pending");
				return;
			end
			want = want_q.pop_front();
			checked++;
			if (want.hit)
				hits++;
			if (got.hit !== want.hit)
				report($sformatf("word %0d hit got %b want %b", checked, got.hit, want.hit));
			for (i = 0; i < 3; i++) begin
				if (got.move_a[i] !== want.move_a[i])
					report($sformatf("word %0d move_a axis %0d got %h want %h",
						checked, i, got.move_a[i], want.move_a[i]));
				if (got.move_b[i] !== want.move_b[i])
					report($sformatf("word %0d move_b axis %0d got %h want %h",
						checked, i, got.move_b[i], want.move_b[i]));
			end
		endtask
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [CoordW-1:0] center_a_x, center_a_y, center_a_z;
	logic signed [CoordW-1:0] center_b_x, center_b_y, center_b_z;
	logic [ExtW-1:0]          extent_sum_x, extent_sum_y, extent_sum_z;
	logic [MassW-1:0]         mass_a, mass_b;
	logic [1:0]               static_flags;
	logic                     out_valid;
	logic                     out_stall;
	logic                     hit;
	logic signed [CoordW-1:0] move_a_x, move_a_y, move_a_z;
	logic signed [CoordW-1:0] move_b_x, move_b_y, move_b_z;

	collide_board board;
	res_t         seen_word;
	int           cycle_cnt = 0;
	int           sent = 0;
	int           in_stall_cycles = 0;
	bit           tx_idle_en = 0;
	bit           rx_idle_en = 0;
	bit           hold_req = 0;

	aabb_collide_resolve_top dut (.*);

	always #10 clk = ~clk;

	// gap length: mostly short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(0, 3);
		else if (r < 95)
			return $urandom_range(4, 16);
		return $urandom_range(20, 80);
	endfunction

	function automatic pair_t make_pair(longint ax, longint ay, longint az,
			longint bx, longint by, longint bz, longint ex, longint ey, longint ez,
			int ma, int mb, logic [1:0] f);
		pair_t p;
		p.ca[AXIS_X]  = ax[CoordW-1:0];
		p.ca[AXIS_Y]  = ay[CoordW-1:0];
		p.ca[AXIS_Z]  = az[CoordW-1:0];
		p.cb[AXIS_X]  = bx[CoordW-1:0];
		p.cb[AXIS_Y]  = by[CoordW-1:0];
		p.cb[AXIS_Z]  = bz[CoordW-1:0];
		p.ext[AXIS_X] = ex[ExtW-1:0];
		p.ext[AXIS_Y] = ey[ExtW-1:0];
		p.ext[AXIS_Z] = ez[ExtW-1:0];
		p.mass_a      = ma[MassW-1:0];
		p.mass_b      = mb[MassW-1:0];
		p.flags       = f;
		return p;
	endfunction

	function automatic longint rand_extent();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(1, 4096);
			4, 5, 6:    return $urandom_range(1, 1 << 24);
			7, 8:       return $urandom_range(1, 32'h7FFF_FFFF);
			default: begin
				case ($urandom_range(0, 2))
					0:       return 0;
					1:       return 1;
					default: return EXT_MAX;
				endcase
			end
		endcase
	endfunction

	function automatic int rand_mass();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return 65535;
			2:       return $urandom_range(1, 255);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	// mostly overlapping pairs with random content, some noise and near misses
	function automatic pair_t rand_pair();
		pair_t  p;
		int     i, kind, r;
		longint a, b, e, m;
		kind = $urandom_range(0, 99);
		for (i = 0; i < 3; i++) begin
			if (kind < 12) begin
				p.ca[i]  = $urandom;
				p.cb[i]  = $urandom;
				p.ext[i] = ExtW'($urandom);
			end else begin
				e = rand_extent();
				r = $urandom_range(0, 19);
				if (r < 17)
					m = (e > 0) ? $urandom_range(0, 32'((e - 1) / 2)) : 0;
				else if (r == 17)
					m = (e > 0) ? (e - 1) / 2 : 0;
				else if (r == 18)
					m = (e + 1) / 2;
				else
					m = $urandom_range(0, 1 << 30);
				if ($urandom_range(0, 1))
					m = -m;
				case ($urandom_range(0, 19))
					0:       a = CMAX;
					1:       a = CMIN;
					default: a = $signed($urandom);
				endcase
				b = a - m;
				if (b > CMAX || b < CMIN)
					b = a + m;
				p.ca[i]  = a[CoordW-1:0];
				p.cb[i]  = b[CoordW-1:0];
				p.ext[i] = e[ExtW-1:0];
			end
		end
		if (kind < 12) begin
			p.mass_a = MassW'($urandom);
			p.mass_b = MassW'($urandom);
			p.flags  = 2'($urandom);
		end else begin
			p.mass_a = MassW'(rand_mass());
			p.mass_b = MassW'(rand_mass());
			if (kind < 17) begin
				p.mass_a = '0;
				p.mass_b = '0;
			end
			case ($urandom_range(0, 9))
				6:       p.flags = STAT_A;
				7:       p.flags = STAT_B;
				8:       p.flags = STAT_A | STAT_B;
				9:       p.flags = 2'($urandom);
				default: p.flags = '0;
			endcase
		end
		return p;
	endfunction

	// offer one pair, hold it until accepted
	task automatic send_pair(input pair_t p);
		int gap;
		gap = tx_idle_en ? gap_len() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		center_a_x   <= p.ca[AXIS_X];
		center_a_y   <= p.ca[AXIS_Y];
		center_a_z   <= p.ca[AXIS_Z];
		center_b_x   <= p.cb[AXIS_X];
		center_b_y   <= p.cb[AXIS_Y];
		center_b_z   <= p.cb[AXIS_Z];
		extent_sum_x <= p.ext[AXIS_X];
		extent_sum_y <= p.ext[AXIS_Y];
		extent_sum_z <= p.ext[AXIS_Z];
		mass_a       <= p.mass_a;
		mass_b       <= p.mass_b;
		static_flags <= p.flags;
		in_valid     <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_pair(p);
		sent++;
	endtask

	// stop offering and wait for every expected word
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// main sequence
	initial begin
		int n, wait_cnt;
		board        = new();
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		out_stall    = 1'b0;
		center_a_x   = '0;
		center_a_y   = '0;
		center_a_z   = '0;
		center_b_x   = '0;
		center_b_y   = '0;
		center_b_z   = '0;
		extent_sum_x = '0;
		extent_sum_y = '0;
		extent_sum_z = '0;
		mass_a       = '0;
		mass_b       = '0;
		static_flags = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: axis choice and ties, touching, extremes, masses, static boxes
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 256, 256, 0));
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 4*ONE, 4*ONE, 4*ONE, 256, 256, 0));
		send_pair(make_pair(ONE, 0, 0, 0, 0, 0, 4*ONE, 4*ONE, 4*ONE, 256, 512, 0));
		send_pair(make_pair(0, -ONE, 0, 0, 0, 0, 4*ONE, 4*ONE, 4*ONE, 512, 256, 0));
		send_pair(make_pair(0, 0, 0, 0, 0, ONE, 4*ONE, 4*ONE, 4*ONE, 100, 700, 0));
		send_pair(make_pair(ONE, ONE, 0, 0, 0, 0, 4*ONE, 4*ONE, 4*ONE, 256, 256, 0));
		send_pair(make_pair(ONE, 0, ONE, 0, 0, 0, 4*ONE, 4*ONE, 4*ONE, 256, 256, 0));
		send_pair(make_pair(0, ONE, ONE, 0, 0, 0, 4*ONE, 4*ONE, 4*ONE, 256, 256, 0));
		send_pair(make_pair(ONE, 0, 0, 0, 0, 0, 2*ONE, 4*ONE, 4*ONE, 256, 256, 0));
		send_pair(make_pair(ONE, 0, 0, 0, 0, 0, 2*ONE+1, 4*ONE, 4*ONE, 256, 256, 0));
		send_pair(make_pair(3, 5, 7, 0, 0, 0, 9, 13, 17, 100, 300, 0));
		send_pair(make_pair(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
			EXT_MAX, EXT_MAX, EXT_MAX, 256, 256, 0));
		send_pair(make_pair(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
			EXT_MAX, EXT_MAX, EXT_MAX, 256, 256, 0));
		send_pair(make_pair(0, 0, 0, 0, 0, 0, EXT_MAX, EXT_MAX, EXT_MAX, 65535, 65535, 0));
		send_pair(make_pair(0, 0, 0, 0, 0, 0, EXT_MAX, EXT_MAX, EXT_MAX, 0, 0, 0));
		send_pair(make_pair(0, 0, 0, 0, 0, 0, EXT_MAX, EXT_MAX, EXT_MAX, 0, 65535, 0));
		send_pair(make_pair(0, 0, 0, 0, 0, 0, EXT_MAX, EXT_MAX, EXT_MAX, 65535, 0, 0));
		send_pair(make_pair(ONE, 2*ONE, 0, 0, 0, 0, 8*ONE, 8*ONE, 8*ONE, 300, 200, STAT_A));
		send_pair(make_pair(ONE, 2*ONE, 0, 0, 0, 0, 8*ONE, 8*ONE, 8*ONE, 300, 200, STAT_B));
		send_pair(make_pair(ONE, 2*ONE, 0, 0, 0, 0, 8*ONE, 8*ONE, 8*ONE, 300, 200,
			STAT_A | STAT_B));
		send_pair(make_pair(CMIN, CMIN, CMAX, CMIN+3, CMIN+ONE, CMAX-5,
			100, 4*ONE, 20, 1, 1, 0));
		send_pair(make_pair(0, 0, 0, 0, 0, 0, EXT_MAX, EXT_MAX, EXT_MAX, 123, 456, STAT_B));
		send_pair(make_pair(0, 0, 0, 0, 0, 0, EXT_MAX, EXT_MAX, EXT_MAX, 123, 456, STAT_A));
		send_pair(make_pair((1 << 30) - 1, 0, 0, 0, 0, 0,
			EXT_MAX, EXT_MAX, EXT_MAX, 7, 9, 0));
		drain_results();

		// random pairs through several idling phases
		for (n = 0; n < N_RAND; n++) begin
			case (n)
				0: begin
					tx_idle_en = 1; rx_idle_en = 1;
				end
				400: begin
					// back-to-back input against a long output hold
					tx_idle_en = 0; hold_req = 1;
				end
				600:  tx_idle_en = 1;
				800:  drain_results();
				900: begin
					tx_idle_en = 0; rx_idle_en = 0;
				end
				1150: tx_idle_en = 1;
				1400: begin
					tx_idle_en = 0; rx_idle_en = 1;
				end
				default: ;
			endcase
			send_pair(rand_pair());
		end

		// wind down
		@(negedge clk);
		in_valid <= 1'b0;
		wait_cnt = 0;
		while (board.pending() != 0 && wait_cnt < DRAIN_LIMIT) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.pending() != 0)
			board.report($sformatf("%0d expected words never arrived", board.pending()));
		$display("summary: %0d pairs sent, %0d words compared, %0d hits, %0d input stall cycles",
			sent, board.checked, board.hits, in_stall_cycles);
		$display("summary: ties, extremes, zero masses, static boxes, a %0d-cycle output hold",
			HOLD_CYCLES);
		if (board.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// output side back-pressure
	initial begin
		int stall_left, run_left;
		stall_left = 0;
		run_left   = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req   = 0;
				run_left   = 0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left == 0 && run_left == 0) begin
				run_left   = $urandom_range(1, 16);
				stall_left = rx_idle_en ? gap_len() : 0;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				run_left--;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (in_valid && in_stall)
				in_stall_cycles++;
			if (out_valid && !out_stall) begin
				seen_word.hit            = hit;
				seen_word.move_a[AXIS_X] = move_a_x;
				seen_word.move_a[AXIS_Y] = move_a_y;
				seen_word.move_a[AXIS_Z] = move_a_z;
				seen_word.move_b[AXIS_X] = move_b_x;
				seen_word.move_b[AXIS_Y] = move_b_y;
				seen_word.move_b[AXIS_Z] = move_b_z;
				board.check_move(seen_word);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected",
				cycle_cnt, board.pending());
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule
